// ===== design/sfh_pkg.sv =====
// Shared types and constants for the square footprint histogram.
// No dependencies; imported by every design file except sfh_ram.
package sfh_pkg;

  localparam int unsigned IDX_W = 10;  // bin index, up to 1024 bins per axis
  localparam int unsigned COV_W = 13;
  localparam logic [COV_W-1:0] COV_MAX = 13'h1fff;

  // Item commands
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_X_ORG = 3'd0;
  localparam logic [2:0] REG_Y_ORG = 3'd1;
  localparam logic [2:0] REG_W_X   = 3'd2;
  localparam logic [2:0] REG_W_Y   = 3'd3;
  localparam logic [2:0] REG_USE_X = 3'd4;
  localparam logic [2:0] REG_USE_Y = 3'd5;
  localparam logic [2:0] REG_HALF  = 3'd6;

  typedef struct packed {
    logic signed [15:0] x_org;
    logic signed [15:0] y_org;
    logic [14:0]        w_x;
    logic [14:0]        w_y;
    logic [6:0]         use_x;
    logic [6:0]         use_y;
    logic [14:0]        half;
  } cfg_t;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,  // result comes from the front alone
    K_ADD   = 2'd1,
    K_READ  = 2'd2,
    K_CLEAR = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [15:0]      weight;
    logic [IDX_W-1:0] xlo;
    logic [IDX_W-1:0] xhi;
    logic [IDX_W-1:0] ylo;
    logic [IDX_W-1:0] yhi;
    logic [COV_W-1:0] covered;
    logic             skipped;
    logic             ierr;
  } job_t;

endpackage

// ===== design/sfh_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sfh_ram #(
  parameter int unsigned W  = 32,
  parameter int unsigned D  = 4096,
  parameter int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);
  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/sfh_queue.sv =====
// Two-entry job queue between front and back.
// Depends on sfh_pkg.
module sfh_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfh_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output sfh_pkg::job_t rdata_o,
  output logic          empty_o
);
  import sfh_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

// ===== design/sfh_front.sv =====
// Front end: accepts requests, sweeps both axes one bin per cycle to find
// the covered index ranges, queues a job. Depends on sfh_pkg.
module sfh_front #(
  parameter int unsigned MAX_X_BINS = 64,
  parameter int unsigned MAX_Y_BINS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfh_pkg::cfg_t      cfg_i,
  input  logic               busy_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] weight_i,
  input  logic [5:0]         read_col_i,
  input  logic [5:0]         read_row_i,
  output logic               push_o,
  output sfh_pkg::job_t      job_o,
  input  logic               full_i
);
  import sfh_pkg::*;

  localparam int unsigned MAXB = (MAX_X_BINS > MAX_Y_BINS) ? MAX_X_BINS : MAX_Y_BINS;
  localparam int unsigned CW   = $clog2(MAXB + 1);
  localparam int unsigned SW   = 30;

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_SWEEP = 3'b010,
    F_PUSH  = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;

  logic [CW-1:0] nx, ny, nmax, i_q;
  logic [14:0]   wx_eff, wy_eff;
  logic signed [SW-1:0] cx_q, cy_q, stx_q, sty_q, p2x_q, p2y_q, h2_q;
  logic signed [SW-1:0] dx, dy, adx, ady;
  logic [15:0]   weight_q;
  logic [IDX_W-1:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic [CW-1:0] cntx_q, cnty_q;
  logic          hitx, hity, accept, need_sweep;
  logic [21:0]   prod;

  // clamp compared at full width, so a small maximum never truncates the count
  assign nx = (32'(cfg_i.use_x) > 32'(MAX_X_BINS)) ? CW'(MAX_X_BINS) : CW'(cfg_i.use_x);
  assign ny = (32'(cfg_i.use_y) > 32'(MAX_Y_BINS)) ? CW'(MAX_Y_BINS) : CW'(cfg_i.use_y);
  assign nmax   = (nx > ny) ? nx : ny;
  assign wx_eff = (cfg_i.w_x == '0) ? 15'd1 : cfg_i.w_x;
  assign wy_eff = (cfg_i.w_y == '0) ? 15'd1 : cfg_i.w_y;

  assign in_stall_o = (state_q != F_IDLE) || full_i || busy_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign need_sweep = (cmd_i == CMD_ADD) && !weight_i[15] && (weight_i != '0)
                      && (nmax != '0);

  // doubled-centre distance test
  assign dx   = cx_q - p2x_q;
  assign dy   = cy_q - p2y_q;
  assign adx  = dx[SW-1] ? -dx : dx;
  assign ady  = dy[SW-1] ? -dy : dy;
  assign hitx = (i_q < nx) && (adx <= h2_q);
  assign hity = (i_q < ny) && (ady <= h2_q);
  assign prod = 22'(cntx_q) * 22'(cnty_q);

  always_comb begin
    job_o    = '0;
    push_o   = 1'b0;
    state_d  = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          job_o.xlo = IDX_W'(read_col_i);
          job_o.ylo = IDX_W'(read_row_i);
          priority if (need_sweep) begin
            state_d = F_SWEEP;
          end else if (cmd_i == CMD_ADD) begin
            push_o        = 1'b1;
            job_o.skipped = weight_i[15] || (weight_i == '0);
          end else if (cmd_i == CMD_READ) begin
            push_o     = 1'b1;
            job_o.kind = K_READ;
            job_o.ierr = (32'(read_col_i) >= 32'(nx)) || (32'(read_row_i) >= 32'(ny));
          end else if (cmd_i == CMD_CLEAR) begin
            push_o     = 1'b1;
            job_o.kind = K_CLEAR;
          end else begin
            push_o = 1'b1;
          end
        end
      end
      F_SWEEP: begin
        if (i_q == nmax - CW'(1)) state_d = F_PUSH;
      end
      F_PUSH: begin
        job_o.covered = (prod > 22'(COV_MAX)) ? COV_MAX : prod[COV_W-1:0];
        job_o.kind    = (prod != '0) ? K_ADD : K_NONE;
        job_o.weight  = weight_q;
        job_o.xlo     = xlo_q;
        job_o.xhi     = xhi_q;
        job_o.ylo     = ylo_q;
        job_o.yhi     = yhi_q;
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= F_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE) begin
      i_q      <= '0;
      cntx_q   <= '0;
      cnty_q   <= '0;
      weight_q <= weight_i;
      p2x_q    <= {{(SW-17){pos_x_i[15]}}, pos_x_i, 1'b0};
      p2y_q    <= {{(SW-17){pos_y_i[15]}}, pos_y_i, 1'b0};
      h2_q     <= {{(SW-16){1'b0}}, cfg_i.half, 1'b0};
      stx_q    <= {{(SW-16){1'b0}}, wx_eff, 1'b0};
      sty_q    <= {{(SW-16){1'b0}}, wy_eff, 1'b0};
      cx_q     <= {{(SW-17){cfg_i.x_org[15]}}, cfg_i.x_org, 1'b0}
                  + {{(SW-15){1'b0}}, wx_eff};
      cy_q     <= {{(SW-17){cfg_i.y_org[15]}}, cfg_i.y_org, 1'b0}
                  + {{(SW-15){1'b0}}, wy_eff};
    end else if (state_q == F_SWEEP) begin
      i_q  <= i_q + CW'(1);
      cx_q <= cx_q + stx_q;
      cy_q <= cy_q + sty_q;
      if (hitx) begin
        if (cntx_q == '0) xlo_q <= IDX_W'(i_q);
        xhi_q  <= IDX_W'(i_q);
        cntx_q <= cntx_q + CW'(1);
      end
      if (hity) begin
        if (cnty_q == '0) ylo_q <= IDX_W'(i_q);
        yhi_q  <= IDX_W'(i_q);
        cnty_q <= cnty_q + CW'(1);
      end
    end
  end
endmodule

// ===== design/sfh_back.sv =====
// Back end: runs queued jobs against the bin store (read-modify-write,
// read, clearing sweep) and holds the result register. Depends on sfh_pkg, sfh_ram.
module sfh_back #(
  parameter int unsigned MAX_X_BINS = 64,
  parameter int unsigned MAX_Y_BINS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sfh_pkg::job_t           job_i,
  input  logic                    empty_i,
  output logic                    pop_o,
  output logic                    busy_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [31:0]             bin_value_o,
  output logic [sfh_pkg::COV_W-1:0] bins_covered_o,
  output logic                    channel_skipped_o,
  output logic                    index_error_o
);
  import sfh_pkg::*;

  localparam int unsigned D  = MAX_X_BINS * MAX_Y_BINS;
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1;

  typedef enum logic [5:0] {
    B_INIT = 6'b000001,
    B_IDLE = 6'b000010,
    B_RD   = 6'b000100,
    B_WAIT = 6'b001000,
    B_CLR  = 6'b010000,
    B_RESP = 6'b100000
  } bstate_e;

  bstate_e state_q, state_d;
  job_t    job_q;
  logic [IDX_W-1:0] x_q, y_q;
  logic [AW-1:0]    addr, clr_q;
  logic [31:0]      rdata, val_q, wdata;
  logic [32:0]      sum;
  logic             we, last_bin, clr_last, out_free;

  assign addr     = AW'(y_q) * AW'(MAX_X_BINS) + AW'(x_q);
  assign sum      = {1'b0, rdata} + {17'b0, job_q.weight};
  assign last_bin = (x_q == job_q.xhi) && (y_q == job_q.yhi);
  assign clr_last = clr_q == AW'(D - 1);
  assign out_free = !out_valid_o || !out_stall_i;
  assign busy_o   = state_q == B_INIT;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;

  always_comb begin
    we      = 1'b0;
    wdata   = '0;
    state_d = state_q;
    unique case (state_q)
      B_INIT, B_CLR: begin
        we = 1'b1;
        if (clr_last) state_d = (state_q == B_INIT) ? B_IDLE : B_RESP;
      end
      B_IDLE: begin
        if (!empty_i) begin
          unique case (job_i.kind)
            K_ADD:   state_d = B_RD;
            K_READ:  state_d = job_i.ierr ? B_RESP : B_RD;
            K_CLEAR: state_d = B_CLR;
            default: state_d = B_RESP;
          endcase
        end
      end
      B_RD: state_d = B_WAIT;
      B_WAIT: begin
        if (job_q.kind == K_ADD) begin
          we      = 1'b1;
          wdata   = sum[32] ? 32'hffff_ffff : sum[31:0];
          state_d = last_bin ? B_RESP : B_RD;
        end else begin
          state_d = B_RESP;
        end
      end
      B_RESP: if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  sfh_ram #(.W(32), .D(D)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ((state_q == B_WAIT) ? addr : clr_q),
    .wdata_i (wdata),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_INIT;
      clr_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_INIT || state_q == B_CLR) clr_q <= clr_last ? '0 : clr_q + AW'(1);
      if (state_q == B_RESP && out_free)  out_valid_o <= 1'b1;
      else if (!out_stall_i)              out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      x_q   <= job_i.xlo;
      y_q   <= job_i.ylo;
      val_q <= '0;
    end else if (state_q == B_WAIT) begin
      if (job_q.kind == K_READ) val_q <= rdata;
      if (x_q == job_q.xhi) begin
        x_q <= job_q.xlo;
        y_q <= y_q + IDX_W'(1);
      end else begin
        x_q <= x_q + IDX_W'(1);
      end
    end
    if (state_q == B_RESP && out_free) begin
      bin_value_o       <= val_q;
      bins_covered_o    <= (job_q.kind == K_ADD) ? job_q.covered : '0;
      channel_skipped_o <= job_q.skipped;
      index_error_o     <= job_q.ierr;
    end
  end
endmodule

// ===== design/square_footprint_histogram.sv =====
// Top level of the square footprint histogram: APB registers, front end,
// job queue and back end. Depends on sfh_pkg, sfh_front, sfh_queue, sfh_back.
//
// Operation: after reset the bin store is cleared by a sweep over all
// MAX_X_BINS*MAX_Y_BINS bins, during which no request is taken. An add
// request is tested in the front end one bin of each axis per cycle (nx/ny
// the clamped bins in use), then the back end reads and writes back each
// covered bin in turn (states B_RD and B_WAIT, a read-modify-write on the
// bin store through its registered read port) before the result state
// B_RESP. An in-range read goes through B_RD, B_WAIT and B_RESP; a clear
// sweeps every bin in B_CLR before B_RESP. The two-entry queue lets the
// front sweep the next add while the back updates bins, and the result
// register lets the back go on while a result waits to be taken. Exactly
// one result per request.
module square_footprint_histogram #(
  parameter int unsigned MAX_X_BINS = 64,
  parameter int unsigned MAX_Y_BINS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] weight_i,
  input  logic [5:0]         read_col_i,
  input  logic [5:0]         read_row_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        bin_value_o,
  output logic [12:0]        bins_covered_o,
  output logic               channel_skipped_o,
  output logic               index_error_o
);
  import sfh_pkg::*;

  cfg_t cfg_q;
  job_t fjob, qjob;
  logic push, pop, full, empty, busy, wr;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_org <= '0;
      cfg_q.y_org <= '0;
      cfg_q.w_x   <= 15'd16;
      cfg_q.w_y   <= 15'd16;
      cfg_q.use_x <= 7'd64;
      cfg_q.use_y <= 7'd64;
      cfg_q.half  <= 15'd24;
    end else if (wr) begin
      unique case (ridx)
        REG_X_ORG: cfg_q.x_org <= pwdata[15:0];
        REG_Y_ORG: cfg_q.y_org <= pwdata[15:0];
        REG_W_X:   cfg_q.w_x   <= pwdata[14:0];
        REG_W_Y:   cfg_q.w_y   <= pwdata[14:0];
        REG_USE_X: cfg_q.use_x <= pwdata[6:0];
        REG_USE_Y: cfg_q.use_y <= pwdata[6:0];
        REG_HALF:  cfg_q.half  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_X_ORG: prdata = {16'b0, cfg_q.x_org};
      REG_Y_ORG: prdata = {16'b0, cfg_q.y_org};
      REG_W_X:   prdata = {17'b0, cfg_q.w_x};
      REG_W_Y:   prdata = {17'b0, cfg_q.w_y};
      REG_USE_X: prdata = {25'b0, cfg_q.use_x};
      REG_USE_Y: prdata = {25'b0, cfg_q.use_y};
      REG_HALF:  prdata = {17'b0, cfg_q.half};
      default:   prdata = '0;
    endcase
  end

  sfh_front #(.MAX_X_BINS(MAX_X_BINS), .MAX_Y_BINS(MAX_Y_BINS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .busy_i(busy),
    .in_valid_i, .in_stall_o, .cmd_i, .pos_x_i, .pos_y_i, .weight_i,
    .read_col_i, .read_row_i, .push_o(push), .job_o(fjob), .full_i(full)
  );

  sfh_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(fjob), .full_o(full),
    .pop_i(pop), .rdata_o(qjob), .empty_o(empty)
  );

  sfh_back #(.MAX_X_BINS(MAX_X_BINS), .MAX_Y_BINS(MAX_Y_BINS)) u_back (
    .clk_i, .rst_ni, .job_i(qjob), .empty_i(empty), .pop_o(pop), .busy_o(busy),
    .out_valid_o, .out_stall_i, .bin_value_o, .bins_covered_o,
    .channel_skipped_o, .index_error_o
  );

  // no push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("queue overflow");
  // requests held off during the clearing sweep after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> in_stall_o)
    else $error("request taken during clearing sweep");
  // an out-of-range read never returns data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && index_error_o) |-> (bin_value_o == '0))
    else $error("index error with data");
  // a skipped channel covers nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && channel_skipped_o) |-> (bins_covered_o == '0))
    else $error("skipped channel with coverage");
endmodule

// ===== sim/square_footprint_histogram_test.sv =====
// Self-checking bench for the histogram: directed table, corner-case grids, then random requests.
// Depends on sfh_pkg and the square_footprint_histogram design; predicts every result on its own.
module square_footprint_histogram_test;
  import sfh_pkg::*;

  localparam int NX_MAX = 64;
  localparam int NY_MAX = 64;
  localparam int N_RANDOM = 1030;
  localparam longint CYCLE_LIMIT = 50000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = CMD_CLEAR;
  logic signed [15:0] pos_x_i = '0, pos_y_i = '0, weight_i = '0;
  logic [5:0] read_col_i = '0, read_row_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] bin_value_o;
  logic [12:0] bins_covered_o;
  logic channel_skipped_o, index_error_o;

  square_footprint_histogram u_top (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // One request and one result as seen at the ports.
  typedef struct {
    logic [1:0] cmd;
    logic signed [15:0] px, py, wt;
    logic [5:0] col, row;
  } request_t;

  typedef struct {
    logic [31:0] value;
    logic [12:0] covered;
    logic skipped, ierr;
  } result_t;

  // Shadow of the block's registers and bin store.
  logic signed [15:0] sh_x_org, sh_y_org;
  logic [14:0] sh_w_x, sh_w_y, sh_half;
  logic [6:0] sh_use_x, sh_use_y;
  logic [31:0] shadow_bins [NX_MAX*NY_MAX];

  result_t pending_results[$];
  int errors = 0;
  int n_results = 0, n_adds = 0, n_reads = 0, n_clears = 0, n_covering = 0;
  longint cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch #%0d at cycle %0d: %s got %0h expected %0h",
             errors + 1, cycles, what, got, want);
    errors++;
  endtask

  // Marks bins along one axis whose doubled centre is within the doubled half size.
  function automatic int axis_hits(input int n, input longint org, input int w,
                                   input longint ctr, input longint half,
                                   output bit hit[64]);
    longint c2, d;
    int cnt;
    cnt = 0;
    for (int i = 0; i < 64; i++) begin
      hit[i] = 1'b0;
      if (i < n) begin
        c2 = 2 * org + longint'(2 * i + 1) * w;
        d = c2 - 2 * ctr;
        if (d < 0) d = -d;
        hit[i] = (d <= 2 * half);
        if (hit[i]) cnt++;
      end
    end
    return cnt;
  endfunction

  // Computes the histogram's result for one request and updates the shadow store.
  function automatic result_t histogram_step(input request_t rq);
    result_t r;
    int nx, ny, cx, cy;
    bit hx[64], hy[64];
    longint s, cov;
    r = '{default: '0};
    nx = (sh_use_x > NX_MAX) ? NX_MAX : sh_use_x;
    ny = (sh_use_y > NY_MAX) ? NY_MAX : sh_use_y;
    case (rq.cmd)
      CMD_ADD: begin
        if (rq.wt <= 0) begin
          r.skipped = 1'b1;
        end else begin
          cx = axis_hits(nx, sh_x_org, (sh_w_x == 0) ? 1 : sh_w_x, rq.px, sh_half, hx);
          cy = axis_hits(ny, sh_y_org, (sh_w_y == 0) ? 1 : sh_w_y, rq.py, sh_half, hy);
          cov = longint'(cx) * cy;
          for (int iy = 0; iy < ny; iy++)
            for (int ix = 0; ix < nx; ix++)
              if (hx[ix] && hy[iy]) begin
                s = longint'(shadow_bins[iy*NX_MAX+ix]) + rq.wt;
                shadow_bins[iy*NX_MAX+ix] = (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
              end
          r.covered = (cov > 8191) ? COV_MAX : cov[12:0];
        end
      end
      CMD_READ: begin
        if (rq.col >= nx || rq.row >= ny) r.ierr = 1'b1;
        else r.value = shadow_bins[rq.row*NX_MAX+rq.col];
      end
      CMD_CLEAR: begin
        foreach (shadow_bins[i]) shadow_bins[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result checker: compares each taken result with the oldest prediction.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", bin_value_o, 0);
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (bin_value_o !== e.value) report_mismatch("bin_value", bin_value_o, e.value);
        if (bins_covered_o !== e.covered)
          report_mismatch("bins_covered", bins_covered_o, e.covered);
        if (channel_skipped_o !== e.skipped)
          report_mismatch("channel_skipped", channel_skipped_o, e.skipped);
        if (index_error_o !== e.ierr) report_mismatch("index_error", index_error_o, e.ierr);
      end
    end
  end

  // Receiver stall pattern: stretches that are each either free-running or randomly stalled.
  initial begin
    int mode_left;
    bit busy_mode;
    mode_left = 0;
    busy_mode = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode_left = $urandom_range(200, 10);
        busy_mode = 1'($urandom_range(1, 0));
      end
      mode_left--;
      out_stall_i <= busy_mode ? ($urandom_range(3, 0) == 0) : 1'b0;
    end
  end

  initial begin
    wait (cycles > CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("*** FAILED ***");
    $finish;
  end

  // Register write over the APB port: setup cycle then access cycle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_X_ORG: sh_x_org = val[15:0];
      REG_Y_ORG: sh_y_org = val[15:0];
      REG_W_X:   sh_w_x = val[14:0];
      REG_W_Y:   sh_w_y = val[14:0];
      REG_USE_X: sh_use_x = val[6:0];
      REG_USE_Y: sh_use_y = val[6:0];
      REG_HALF:  sh_half = val[14:0];
      default: ;
    endcase
  endtask

  // Lets all predicted results drain and then idles, before any register write.
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Drives one request; valid stays high across back-to-back requests.
  // Without hold, valid drops for one cycle before the next request starts.
  task automatic send_request(input request_t rq, input bit hold_valid);
    in_valid_i <= 1'b1;
    cmd_i <= rq.cmd; pos_x_i <= rq.px; pos_y_i <= rq.py; weight_i <= rq.wt;
    read_col_i <= rq.col; read_row_i <= rq.row;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.insert(pending_results.size(), histogram_step(rq));
    case (rq.cmd)
      CMD_ADD: begin
        n_adds++;
        if (pending_results[$].covered != 0) n_covering++;
      end
      CMD_READ: n_reads++;
      CMD_CLEAR: n_clears++;
      default: ;
    endcase
    @(negedge clk_i);
    if (!hold_valid) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Random request, mostly adds over the grid region with reads, rare clears and rare unused commands.
  function automatic request_t random_request();
    request_t rq;
    int pick;
    pick = $urandom_range(99, 0);
    rq.px = 16'($urandom); rq.py = 16'($urandom); rq.wt = 16'($urandom);
    rq.col = 6'($urandom); rq.row = 6'($urandom);
    if (pick < 55) begin
      rq.cmd = CMD_ADD;
      if ($urandom_range(9, 0) != 0) begin
        // centre near the grid so footprints actually land
        rq.px = 16'(sh_x_org + $signed($urandom_range(1200, 0)) - 100);
        rq.py = 16'(sh_y_org + $signed($urandom_range(1200, 0)) - 100);
        if ($urandom_range(3, 0) != 0) rq.wt = 16'($urandom_range(32767, 1));
      end
    end else if (pick < 95) begin
      rq.cmd = CMD_READ;
      if ($urandom_range(3, 0) != 0) begin
        rq.col = 6'($urandom_range(15, 0));
        rq.row = 6'($urandom_range(15, 0));
      end
    end else if (pick < 98) begin
      rq.cmd = CMD_CLEAR;
    end else begin
      rq.cmd = 2'd3;
    end
    return rq;
  endfunction

  typedef struct {
    request_t rq;
    bit known;      // expected result typed in below
    result_t res;
  } table_row_t;

  table_row_t directed[$];

  function automatic table_row_t row_of(input logic [1:0] c, input int x, input int y,
                                        input int w, input int col, input int row,
                                        input bit known, input logic [31:0] v,
                                        input int cov, input bit sk, input bit ie);
    table_row_t t;
    t.rq = '{cmd: c, px: 16'(x), py: 16'(y), wt: 16'(w), col: 6'(col), row: 6'(row)};
    t.known = known;
    t.res = '{value: v, covered: 13'(cov), skipped: sk, ierr: ie};
    return t;
  endfunction

  initial begin
    int burst;
    result_t got;
    // reset-time shadow state
    sh_x_org = 0; sh_y_org = 0; sh_w_x = 16; sh_w_y = 16;
    sh_use_x = 64; sh_use_y = 64; sh_half = 24;
    foreach (shadow_bins[i]) shadow_bins[i] = '0;

    // Default grid: 16-unit bins, half 24 -> 3x3 footprint away from the edges.
    directed = {directed, row_of(CMD_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0)};  // cleared at reset
    directed = {directed, row_of(CMD_READ, 0, 0, 0, 63, 63, 1, 0, 0, 0, 0)};
    directed = {directed, row_of(CMD_ADD, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0)};   // zero weight skips
    directed = {directed, row_of(CMD_ADD, 0, 0, -32768, 0, 0, 1, 0, 0, 1, 0)}; // negative
    directed = {directed, row_of(CMD_ADD, 40, 40, 1, 0, 0, 1, 0, 9, 0, 0)};
    directed = {directed, row_of(CMD_ADD, 32767, 32767, 32767, 0, 0, 1, 0, 0, 0, 0)};
    directed = {directed, row_of(CMD_ADD, -32768, -32768, 32767, 0, 0, 1, 0, 0, 0, 0)};
    directed = {directed, row_of(CMD_ADD, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 0)}; // corner clip
    directed = {directed, row_of(CMD_ADD, 1016, 1016, 5, 0, 0, 0, 0, 0, 0, 0)};
    directed = {directed, row_of(CMD_READ, 0, 0, 0, 2, 2, 0, 0, 0, 0, 0)};
    directed = {directed, row_of(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    directed = {directed, row_of(2'd3, -1, -1, -1, 63, 63, 1, 0, 0, 0, 0)}; // unused command
    directed = {directed, row_of(CMD_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0)};
    directed = {directed, row_of(CMD_READ, 0, 0, 0, 2, 2, 1, 0, 0, 0, 0)};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      send_request(directed[i].rq, 1'b0);
      if (directed[i].known) begin
        got = pending_results[$];
        if (got != directed[i].res) report_mismatch("directed row prediction", i, 0);
      end
    end
    drain_results();

    // Single-bin grid with a full-grid footprint, max weights back to back.
    write_reg(REG_USE_X, 1);
    write_reg(REG_USE_Y, 1);
    write_reg(REG_HALF, 32'h7fff);
    repeat (8) send_request('{cmd: CMD_ADD, px: 0, py: 0, wt: 32767, col: 0, row: 0}, 1'b1);
    in_valid_i <= 1'b0;
    drain_results();
    // Zero bins, over-max counts, zero widths, extreme origins.
    write_reg(REG_USE_X, 0);
    send_request('{cmd: CMD_ADD, px: 0, py: 0, wt: 9, col: 0, row: 0}, 1'b0);
    send_request('{cmd: CMD_READ, px: 0, py: 0, wt: 0, col: 0, row: 0}, 1'b0);
    drain_results();
    write_reg(REG_USE_X, 127);
    write_reg(REG_USE_Y, 127);
    write_reg(REG_W_X, 0);
    write_reg(REG_W_Y, 0);
    write_reg(REG_X_ORG, 32'h8000);
    write_reg(REG_Y_ORG, 32'h7fff);
    send_request('{cmd: CMD_ADD, px: -32768, py: 32767, wt: 3, col: 0, row: 0}, 1'b0);
    send_request('{cmd: CMD_READ, px: 0, py: 0, wt: 0, col: 63, row: 0}, 1'b0);
    drain_results();
    write_reg(REG_W_X, 32'h7fff);
    write_reg(REG_W_Y, 32'h7fff);
    write_reg(REG_HALF, 32'h7fff);
    send_request('{cmd: CMD_ADD, px: 0, py: 0, wt: 2, col: 0, row: 0}, 1'b0);
    drain_results();
    send_request('{cmd: CMD_CLEAR, px: 0, py: 0, wt: 0, col: 0, row: 0}, 1'b0);
    drain_results();

    // Random phases, each under its own grid setting.
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(REG_X_ORG, (phase == 0) ? 0 : $signed($urandom_range(600, 0)) - 300);
      write_reg(REG_Y_ORG, (phase == 0) ? 0 : $signed($urandom_range(600, 0)) - 300);
      write_reg(REG_W_X, $urandom_range(40, 1));
      write_reg(REG_W_Y, $urandom_range(40, 1));
      write_reg(REG_USE_X, (phase == 4) ? 64 : $urandom_range(70, 1));
      write_reg(REG_USE_Y, (phase == 4) ? 64 : $urandom_range(70, 1));
      write_reg(REG_HALF, (phase == 3) ? 0 : $urandom_range(60, 0));
      for (int n = 0; n < N_RANDOM / 5; n += burst) begin
        burst = $urandom_range(12, 1);
        for (int b = 0; b < burst; b++) send_request(random_request(), b != burst - 1);
        if ($urandom_range(1, 0)) repeat ($urandom_range(30, 1)) @(negedge clk_i);
      end
      drain_results();
    end

    $display("covered %0d adds (%0d landing on bins), %0d reads, %0d clears;",
             n_adds, n_covering, n_reads, n_clears);
    $display("%0d results checked against the predictor", n_results);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
